/* hw/rtl/hdlct3_pkg.sv */
package hdlct3_pkg;

   localparam int HDR_DEPTH = 8;
   localparam int CNT_W     = 12;
   localparam int SIZE_W    = 13;
   localparam int CTL_ENTRIES = 9;

   localparam logic [7:0]       FLAG_BYTE = 8'h7E;
   localparam logic [7:0]       FORMAT_ID = 8'hA0;
   localparam logic [15:0]      CRC_INIT  = 16'hFFFF;
   localparam logic [15:0]      CRC_POLY  = 16'h8408;
   localparam logic [15:0]      CRC_GOOD  = 16'hF0B8;
   localparam logic [CNT_W-1:0] CNT_MAX   = 12'd4095;

   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_FLAG    = 3'd1;
   localparam logic [2:0] STATUS_FCS     = 3'd2;
   localparam logic [2:0] STATUS_FORMAT  = 3'd3;
   localparam logic [2:0] STATUS_SIZE    = 3'd4;
   localparam logic [2:0] STATUS_ADDRESS = 3'd5;
   localparam logic [2:0] STATUS_CONTROL = 3'd6;

   localparam logic [3:0] FT_BAD = 4'd0;

   localparam logic [2:0] ASZ_ONE  = 3'd1;
   localparam logic [2:0] ASZ_TWO  = 3'd2;
   localparam logic [2:0] ASZ_FOUR = 3'd4;

   // Control byte classes in priority order: I, RR, RNR, SNRM, DISC, UA, DM, FRMR, UI.
   localparam logic [7:0] CTL_MASK [CTL_ENTRIES] =
      '{8'h01, 8'h0F, 8'h0F, 8'hEF, 8'hEF, 8'hEF, 8'hEF, 8'hEF, 8'hEF};
   localparam logic [7:0] CTL_VAL [CTL_ENTRIES] =
      '{8'h00, 8'h01, 8'h05, 8'h83, 8'h43, 8'h63, 8'h0F, 8'h87, 8'h03};

   typedef logic [HDR_DEPTH-1:0][7:0] hdr_arr_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [10:0] frame_length;
      logic        segmented;
      logic [2:0]  srv_addr_len;
      logic [13:0] srv_upper_addr;
      logic [13:0] physical_address;
      logic [6:0]  client_sap;
      logic [3:0]  frame_type;
      logic        pf_bit;
      logic [2:0]  recv_seq;
      logic [2:0]  send_seq;
   } result_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* hw/rtl/hdlct3_if.sv */
interface hdlct3_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_end;

   modport source(output valid, output data_byte, output frame_end, input ready);
   modport sink(input valid, input data_byte, input frame_end, output ready);
endinterface

interface hdlct3_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [10:0] frame_length;
   logic        segmented;
   logic [2:0]  srv_addr_len;
   logic [13:0] srv_upper_addr;
   logic [13:0] physical_address;
   logic [6:0]  client_sap;
   logic [3:0]  frame_type;
   logic        pf_bit;
   logic [2:0]  recv_seq;
   logic [2:0]  send_seq;

   modport source(output valid, output status, output frame_length, output segmented,
                  output srv_addr_len, output srv_upper_addr, output physical_address,
                  output client_sap, output frame_type, output pf_bit,
                  output recv_seq, output send_seq, input ready);
   modport sink(input valid, input status, input frame_length, input segmented,
                input srv_addr_len, input srv_upper_addr, input physical_address,
                input client_sap, input frame_type, input pf_bit,
                input recv_seq, input send_seq, output ready);
endinterface

/* hw/rtl/hdlc_type3_frame_decoder_unit.sv */
// Channel    Direction  Payload                                 Transfer when
// req_bus    in         data_byte, frame_end                    valid && ready
// rsp_bus    out        status, frame fields, control fields    valid && ready
//
// A byte is taken into an input register, then advances the frame state and,
// on the closing byte, loads the decoded frame into the result register.
// One byte per cycle is sustained.
// Only the closing byte waits on a full result register; other bytes keep flowing.
// Reset is synchronous and returns the frame state to the start of a frame.
module hdlc_type3_frame_decoder_unit (
   input logic         clock,
   input logic         reset,
   hdlct3_req_if.sink  req_bus,
   hdlct3_rsp_if.source rsp_bus
);
   import hdlct3_pkg::*;

   logic             in_vld_ff, in_vld_in;
   logic [7:0]       in_byte_ff;
   logic             in_end_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      fcs_ff, fcs_in;
   logic             open_ff, open_in;
   hdr_arr_type      hdr_ff;
   logic             out_vld_ff, out_vld_in;
   result_type       out_res_ff;

   logic             out_free;
   logic             s1_go;
   logic             open_now;
   hdr_arr_type      hdr_view;
   logic [SIZE_W-1:0] size;
   result_type       dec_res;

   assign out_free     = !out_vld_ff || rsp_bus.ready;
   assign s1_go        = in_vld_ff && (!in_end_ff || out_free);
   assign req_bus.ready = !in_vld_ff || s1_go;
   assign in_vld_in    = req_bus.valid ? 1'b1 : (in_vld_ff && !s1_go);

   assign open_now = (cnt_ff == '0) ? (in_byte_ff == FLAG_BYTE) : open_ff;
   assign size     = SIZE_W'(cnt_ff) + SIZE_W'(1);

   always_comb begin
      for (int k = 0; k < HDR_DEPTH; k++) begin
         hdr_view[k] = (cnt_ff == CNT_W'(k + 1)) ? in_byte_ff : hdr_ff[k];
      end
   end

   always_comb begin
      if (in_end_ff) begin
         cnt_in  = '0;
         fcs_in  = CRC_INIT;
         open_in = 1'b0;
      end else begin
         cnt_in  = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + CNT_W'(1);
         fcs_in  = (cnt_ff == '0) ? fcs_ff : crc_step(fcs_ff, in_byte_ff);
         open_in = open_now;
      end
   end

   assign out_vld_in = (s1_go && in_end_ff) ? 1'b1 : (out_vld_ff && !rsp_bus.ready);

   hdlct3_decode u_decode (
      .open_flag_i (open_now),
      .last_byte_i (in_byte_ff),
      .fcs_i       (fcs_ff),
      .size_i      (size),
      .hdr_i       (hdr_view),
      .result_o    (dec_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         cnt_ff     <= '0;
         fcs_ff     <= CRC_INIT;
         open_ff    <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (s1_go) begin
            cnt_ff  <= cnt_in;
            fcs_ff  <= fcs_in;
            open_ff <= open_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff <= req_bus.data_byte;
         in_end_ff  <= req_bus.frame_end;
      end
      if (s1_go) begin
         hdr_ff <= hdr_view;
      end
      if (s1_go && in_end_ff) begin
         out_res_ff <= dec_res;
      end
   end

   assign rsp_bus.valid            = out_vld_ff;
   assign rsp_bus.status           = out_res_ff.status;
   assign rsp_bus.frame_length     = out_res_ff.frame_length;
   assign rsp_bus.segmented        = out_res_ff.segmented;
   assign rsp_bus.srv_addr_len     = out_res_ff.srv_addr_len;
   assign rsp_bus.srv_upper_addr   = out_res_ff.srv_upper_addr;
   assign rsp_bus.physical_address = out_res_ff.physical_address;
   assign rsp_bus.client_sap       = out_res_ff.client_sap;
   assign rsp_bus.frame_type       = out_res_ff.frame_type;
   assign rsp_bus.pf_bit           = out_res_ff.pf_bit;
   assign rsp_bus.recv_seq         = out_res_ff.recv_seq;
   assign rsp_bus.send_seq         = out_res_ff.send_seq;

   // A waiting result is never overwritten by the next closing byte.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (s1_go && in_end_ff) |-> out_free)
      else $error("result register overwritten");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(s1_go && in_end_ff))
      else $error("result without a closing byte");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (s1_go && in_end_ff) |=> (cnt_ff == '0 && fcs_ff == CRC_INIT && !open_ff))
      else $error("frame state not restarted");

   a_ok_has_type: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_res_ff.status == STATUS_OK) |-> out_res_ff.frame_type != FT_BAD)
      else $error("accepted frame without a type");

endmodule

/* hw/rtl/hdlct3_decode.sv */
module hdlct3_decode (
   input  logic                                open_flag_i,
   input  logic [7:0]                          last_byte_i,
   input  logic [15:0]                         fcs_i,
   input  logic [hdlct3_pkg::SIZE_W-1:0]       size_i,
   input  hdlct3_pkg::hdr_arr_type             hdr_i,
   output hdlct3_pkg::result_type              result_o
);
   import hdlct3_pkg::*;

   always_comb begin
      logic [10:0]       len;
      logic [7:0]        f0;
      logic [7:0]        f1;
      logic [7:0]        cl;
      logic [7:0]        cf;
      logic [2:0]        asz;
      logic [13:0]       up;
      logic [13:0]       lo;
      logic              addr_ok;
      logic              found;
      logic [SIZE_W-1:0] min_size;

      result_o = '0;
      f0       = hdr_i[0];
      f1       = hdr_i[1];
      len      = {f0[2:0], f1};
      asz      = '0;
      up       = '0;
      lo       = '0;
      addr_ok  = 1'b1;
      cl       = '0;
      cf       = '0;
      found    = 1'b0;
      min_size = '0;

      if (hdr_i[2][0]) begin
         asz = ASZ_ONE;
         up  = {7'd0, hdr_i[2][7:1]};
      end else if (hdr_i[3][0]) begin
         asz = ASZ_TWO;
         up  = {7'd0, hdr_i[2][7:1]};
         lo  = {7'd0, hdr_i[3][7:1]};
      end else if (!hdr_i[4][0] && hdr_i[5][0]) begin
         asz = ASZ_FOUR;
         up  = {hdr_i[2][7:1], hdr_i[3][7:1]};
         lo  = {hdr_i[4][7:1], hdr_i[5][7:1]};
      end else begin
         addr_ok = 1'b0;
      end
      min_size = SIZE_W'(8) + SIZE_W'(asz);

      unique case (asz)
         ASZ_ONE: begin
            cl = hdr_i[3];
            cf = hdr_i[4];
         end
         ASZ_TWO: begin
            cl = hdr_i[4];
            cf = hdr_i[5];
         end
         default: begin
            cl = hdr_i[6];
            cf = hdr_i[7];
         end
      endcase

      priority if (!(open_flag_i && last_byte_i == FLAG_BYTE)) begin
         result_o.status = STATUS_FLAG;
      end else if (fcs_i != CRC_GOOD) begin
         result_o.status = STATUS_FCS;
      end else if (f0[7:4] != FORMAT_ID[7:4]) begin
         result_o.status = STATUS_FORMAT;
      end else begin
         result_o.frame_length = len;
         result_o.segmented    = f0[3];
         priority if ((SIZE_W'(len) + SIZE_W'(2)) != size_i || size_i < SIZE_W'(9)) begin
            result_o.status = STATUS_SIZE;
         end else if (!addr_ok) begin
            result_o.status = STATUS_ADDRESS;
         end else begin
            result_o.srv_addr_len     = asz;
            result_o.srv_upper_addr   = up;
            result_o.physical_address = lo;
            priority if (size_i < min_size) begin
               result_o.status = STATUS_SIZE;
            end else if (!cl[0]) begin
               result_o.status = STATUS_ADDRESS;
            end else begin
               result_o.client_sap = cl[7:1];
               result_o.pf_bit     = cf[4];
               result_o.recv_seq   = cf[7:5];
               result_o.send_seq   = cf[3:1];
               result_o.frame_type = FT_BAD;
               for (int i = 0; i < CTL_ENTRIES; i++) begin
                  if (!found && (cf & CTL_MASK[i]) == CTL_VAL[i]) begin
                     found               = 1'b1;
                     result_o.frame_type = 4'(i + 1);
                  end
               end
               result_o.status = found ? STATUS_OK : STATUS_CONTROL;
            end
         end
      end
   end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
   import hdlct3_pkg::*;

   localparam int ITEM_TARGET = 1950;
   localparam int MIN_FRAME   = 9;
   localparam int DIR_ROWS    = 27;
   localparam int LONG_INFO   = 700;

   typedef enum logic [1:0] {BK_LITERAL, BK_FCS_LO, BK_FCS_HI} byte_kind_type;

   typedef enum int {
      FM_GOOD, FM_BITFLIP, FM_BAD_FORMAT, FM_BAD_LENGTH, FM_BAD_SERVER,
      FM_EVEN_CLIENT, FM_SHORT, FM_NOISE, FM_OVERLONG
   } frame_mode_type;

   typedef struct {
      logic [7:0]    value;
      byte_kind_type kind;
      logic          last;
      logic          has_exp;
      logic [2:0]    exp_status;
      logic [10:0]   exp_len;
      logic          exp_seg;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hdlct3_req_if req_bus ();
   hdlct3_rsp_if rsp_bus ();

   hdlc_type3_frame_decoder_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #4 clock = ~clock;

   // Frame tracking state of the predictor.
   logic [CNT_W-1:0] frame_count;
   logic [15:0]      fcs_res;
   logic             open_ok;
   logic [7:0]       hdr_seen [HDR_DEPTH];

   result_type  pending_decodes [$];
   logic [7:0]  frame_q [$];
   int          fail_count   = 0;
   int          bytes_sent   = 0;
   int          tx_idle_pct  = 30;
   int          rx_stall_pct = 30;
   int          rx_stall_left = 0;

   dir_row_type dir_table [DIR_ROWS] = '{
      '{8'h00, BK_LITERAL, 1'b1, 1'b1, STATUS_FLAG,   11'd0,    1'b0},
      '{8'h7E, BK_LITERAL, 1'b1, 1'b1, STATUS_FCS,    11'd0,    1'b0},
      '{8'hFF, BK_LITERAL, 1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h7E, BK_LITERAL, 1'b1, 1'b1, STATUS_FLAG,   11'd0,    1'b0},
      '{8'h7E, BK_LITERAL, 1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h7E, BK_LITERAL, 1'b1, 1'b1, STATUS_FCS,    11'd0,    1'b0},
      '{8'h7E, BK_LITERAL, 1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'hA0, BK_LITERAL, 1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h07, BK_LITERAL, 1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h03, BK_LITERAL, 1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h21, BK_LITERAL, 1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h93, BK_LITERAL, 1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h00, BK_FCS_LO,  1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h00, BK_FCS_HI,  1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h7E, BK_LITERAL, 1'b1, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h7E, BK_LITERAL, 1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h50, BK_LITERAL, 1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h07, BK_LITERAL, 1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h00, BK_FCS_LO,  1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h00, BK_FCS_HI,  1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h7E, BK_LITERAL, 1'b1, 1'b1, STATUS_FORMAT, 11'd0,    1'b0},
      '{8'h7E, BK_LITERAL, 1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'hAF, BK_LITERAL, 1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'hFF, BK_LITERAL, 1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h00, BK_FCS_LO,  1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h00, BK_FCS_HI,  1'b0, 1'b0, STATUS_OK,     11'd0,    1'b0},
      '{8'h7E, BK_LITERAL, 1'b1, 1'b1, STATUS_SIZE,   11'd2047, 1'b1}
   };

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic result_type decode_frame(input int size, input logic [7:0] last_b);
      result_type  r;
      logic [7:0]  f0, f1, a0, a1, a2, a3, cl, cf;
      int          len;
      int          asz;
      logic [13:0] up, lo;
      r  = '0;
      up = '0;
      lo = '0;
      if (!(open_ok && last_b == FLAG_BYTE)) begin
         r.status = STATUS_FLAG;
         return r;
      end
      if (fcs_res != CRC_GOOD) begin
         r.status = STATUS_FCS;
         return r;
      end
      f0 = hdr_seen[0];
      f1 = hdr_seen[1];
      if ((f0 & 8'hF0) != FORMAT_ID) begin
         r.status = STATUS_FORMAT;
         return r;
      end
      len = {f0[2:0], f1};
      r.frame_length = {f0[2:0], f1};
      r.segmented    = f0[3];
      if (len + 2 != size || size < MIN_FRAME) begin
         r.status = STATUS_SIZE;
         return r;
      end
      a0 = hdr_seen[2];
      a1 = hdr_seen[3];
      a2 = hdr_seen[4];
      a3 = hdr_seen[5];
      if (a0[0]) begin
         asz = ASZ_ONE;
         up  = {7'd0, a0[7:1]};
      end else if (a1[0]) begin
         asz = ASZ_TWO;
         up  = {7'd0, a0[7:1]};
         lo  = {7'd0, a1[7:1]};
      end else if (!a2[0] && a3[0]) begin
         asz = ASZ_FOUR;
         up  = {a0[7:1], a1[7:1]};
         lo  = {a2[7:1], a3[7:1]};
      end else begin
         r.status = STATUS_ADDRESS;
         return r;
      end
      r.srv_addr_len     = 3'(asz);
      r.srv_upper_addr   = up;
      r.physical_address = lo;
      if (size < 8 + asz) begin
         r.status = STATUS_SIZE;
         return r;
      end
      cl = hdr_seen[(2 + asz) % HDR_DEPTH];
      if (!cl[0]) begin
         r.status = STATUS_ADDRESS;
         return r;
      end
      r.client_sap = cl[7:1];
      cf = hdr_seen[(3 + asz) % HDR_DEPTH];
      r.pf_bit     = cf[4];
      r.recv_seq   = cf[7:5];
      r.send_seq   = cf[3:1];
      for (int i = 0; i < CTL_ENTRIES; i++) begin
         if ((cf & CTL_MASK[i]) == CTL_VAL[i]) begin
            r.frame_type = 4'(i + 1);
            r.status     = STATUS_OK;
            return r;
         end
      end
      r.frame_type = FT_BAD;
      r.status     = STATUS_CONTROL;
      return r;
   endfunction

   function automatic logic track_byte(input logic [7:0] b, input logic last,
                                       output result_type r);
      int pos;
      r   = '0;
      pos = int'(frame_count);
      if (pos == 0) begin
         open_ok = (b == FLAG_BYTE);
      end
      if (pos >= 1 && pos <= HDR_DEPTH) begin
         hdr_seen[pos - 1] = b;
      end
      if (last) begin
         r           = decode_frame(pos + 1, b);
         frame_count = '0;
         fcs_res     = CRC_INIT;
         open_ok     = 1'b0;
         return 1'b1;
      end
      if (pos != 0) begin
         fcs_res = crc_update(fcs_res, b);
      end
      if (frame_count < CNT_MAX) begin
         frame_count = frame_count + 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 8);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic last, input logic typed,
                            input result_type typed_res);
      result_type r;
      int         gap;
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.frame_end <= last;
      do @(posedge clock); while (!req_bus.ready);
      if (track_byte(b, last, r)) begin
         pending_decodes.push_back(typed ? typed_res : r);
      end
      bytes_sent++;
      gap = ($urandom_range(0, 99) < tx_idle_pct) ? idle_len() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
   endtask

   task automatic make_frame(input frame_mode_type mode);
      logic [7:0]  body [$];
      logic [7:0]  ab, cf;
      logic [15:0] crc, fcs;
      logic [10:0] len;
      logic [3:0]  nib;
      logic        seg;
      int          asz, info, n, cls, r, i;
      body = {};
      frame_q = {};
      if (mode == FM_NOISE) begin
         n = $urandom_range(1, 12);
         for (i = 0; i < n; i++) begin
            frame_q.push_back(8'($urandom));
         end
         if ($urandom_range(0, 1)) begin
            frame_q[0] = FLAG_BYTE;
         end
         return;
      end
      if (mode == FM_SHORT) begin
         asz = $urandom_range(0, 1) ? 2 : 4;
      end else begin
         r   = $urandom_range(0, 2);
         asz = (r == 0) ? 1 : ((r == 1) ? 2 : 4);
      end
      body.push_back(8'h00);
      body.push_back(8'h00);
      for (i = 0; i < asz; i++) begin
         ab    = 8'($urandom_range(0, 127)) << 1;
         ab[0] = (i == asz - 1);
         body.push_back(ab);
      end
      if (mode == FM_SHORT) begin
         n = (asz == 2) ? 1 : $urandom_range(0, 1);
         for (i = 0; i < n; i++) begin
            body.push_back(8'($urandom));
         end
      end else begin
         ab    = 8'($urandom_range(0, 127)) << 1;
         ab[0] = 1'b1;
         body.push_back(ab);
         if ($urandom_range(0, 99) < 85) begin
            cls = $urandom_range(0, CTL_ENTRIES - 1);
            cf  = (8'($urandom) & ~CTL_MASK[cls]) | CTL_VAL[cls];
         end else begin
            cf = 8'($urandom);
         end
         body.push_back(cf);
         r = $urandom_range(0, 99);
         if (mode == FM_OVERLONG) begin
            info = LONG_INFO;
         end else if (r < 85) begin
            info = $urandom_range(0, 6);
         end else if (r < 97) begin
            info = $urandom_range(7, 40);
         end else begin
            info = $urandom_range(41, 200);
         end
         for (i = 0; i < info; i++) begin
            body.push_back(8'($urandom));
         end
      end
      if (mode == FM_BAD_SERVER) begin
         while (body.size() < 6) body.push_back(8'($urandom));
         body[2][0] = 1'b0;
         body[3][0] = 1'b0;
         if ($urandom_range(0, 1)) begin
            body[4][0] = 1'b1;
         end else begin
            body[5][0] = 1'b0;
         end
      end
      if (mode == FM_EVEN_CLIENT) begin
         body[2 + asz][0] = 1'b0;
      end
      len = 11'(body.size() + 2);
      if (mode == FM_BAD_LENGTH) begin
         len = len ^ 11'($urandom_range(1, 2047));
      end
      seg = $urandom_range(0, 1);
      nib = 4'hA;
      if (mode == FM_BAD_FORMAT) begin
         nib = 4'($urandom_range(0, 14));
         if (nib >= 4'hA) begin
            nib = nib + 1'b1;
         end
      end
      body[0] = {nib, seg, len[10:8]};
      body[1] = len[7:0];
      crc = CRC_INIT;
      foreach (body[k]) begin
         crc = crc_update(crc, body[k]);
      end
      fcs = ~crc;
      body.push_back(fcs[7:0]);
      body.push_back(fcs[15:8]);
      frame_q.push_back(FLAG_BYTE);
      foreach (body[k]) begin
         frame_q.push_back(body[k]);
      end
      frame_q.push_back(FLAG_BYTE);
      if (mode == FM_BITFLIP) begin
         i = $urandom_range(0, frame_q.size() - 1);
         frame_q[i] = frame_q[i] ^ (8'h01 << $urandom_range(0, 7));
      end
   endtask

   function automatic frame_mode_type pick_mode();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return FM_GOOD;
      if (r < 75) return FM_BITFLIP;
      if (r < 79) return FM_BAD_FORMAT;
      if (r < 83) return FM_BAD_LENGTH;
      if (r < 87) return FM_BAD_SERVER;
      if (r < 91) return FM_EVEN_CLIENT;
      if (r < 94) return FM_SHORT;
      return FM_NOISE;
   endfunction

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned got_v);
      if (exp_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
         fail_count++;
      end
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
            if (pending_decodes.size() == 0) begin
               $display("%0t: result transfer with status %0d, expected none", $time,
                        rsp_bus.status);
               fail_count++;
            end else begin
               result_type e;
               e = pending_decodes.pop_front();
               check_field("status", e.status, rsp_bus.status);
               check_field("frame_length", e.frame_length, rsp_bus.frame_length);
               check_field("segmented", e.segmented, rsp_bus.segmented);
               check_field("srv_addr_len", e.srv_addr_len, rsp_bus.srv_addr_len);
               check_field("srv_upper_addr", e.srv_upper_addr, rsp_bus.srv_upper_addr);
               check_field("physical_address", e.physical_address,
                           rsp_bus.physical_address);
               check_field("client_sap", e.client_sap, rsp_bus.client_sap);
               check_field("frame_type", e.frame_type, rsp_bus.frame_type);
               check_field("pf_bit", e.pf_bit, rsp_bus.pf_bit);
               check_field("recv_seq", e.recv_seq, rsp_bus.recv_seq);
               check_field("send_seq", e.send_seq, rsp_bus.send_seq);
            end
         end
         @(negedge clock);
         if (rx_stall_left == 0 && $urandom_range(0, 99) < rx_stall_pct) begin
            rx_stall_left = idle_len();
         end
         if (rx_stall_left > 0) begin
            rx_stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [15:0] tx_crc, tx_fcs;
      logic [7:0]  b;
      int          tx_pos;
      int          frames_sent;
      int          ph;
      result_type  typed_res;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.frame_end = 1'b0;
      frame_count = '0;
      fcs_res     = CRC_INIT;
      open_ok     = 1'b0;
      foreach (hdr_seen[k]) begin
         hdr_seen[k] = 8'h00;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tx_pos = 0;
      tx_crc = CRC_INIT;
      tx_fcs = 16'h0000;
      for (int i = 0; i < DIR_ROWS; i++) begin
         case (dir_table[i].kind)
            BK_FCS_LO: begin
               tx_fcs = ~tx_crc;
               b = tx_fcs[7:0];
            end
            BK_FCS_HI: begin
               b = tx_fcs[15:8];
            end
            default: begin
               b = dir_table[i].value;
            end
         endcase
         typed_res = '0;
         typed_res.status       = dir_table[i].exp_status;
         typed_res.frame_length = dir_table[i].exp_len;
         typed_res.segmented    = dir_table[i].exp_seg;
         push_byte(b, dir_table[i].last, dir_table[i].has_exp, typed_res);
         if (dir_table[i].last) begin
            tx_pos = 0;
            tx_crc = CRC_INIT;
         end else begin
            if (tx_pos != 0) begin
               tx_crc = crc_update(tx_crc, b);
            end
            tx_pos++;
         end
      end
      wait_drained();

      frames_sent = 0;
      while (bytes_sent < ITEM_TARGET) begin
         if (frames_sent % 25 == 0) begin
            ph = $urandom_range(0, 3);
            tx_idle_pct  = ph[0] ? 30 : 0;
            rx_stall_pct = ph[1] ? 30 : 0;
         end
         if (frames_sent % 40 == 17) begin
            wait_drained();
         end
         make_frame((frames_sent == 10) ? FM_OVERLONG : pick_mode());
         for (int i = 0; i < frame_q.size(); i++) begin
            push_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, '0);
         end
         frames_sent++;
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("hdlc_type3_frame_decoder_unit verification clean");
      end else begin
         $display("hdlc_type3_frame_decoder_unit verification failed");
      end
      $finish;
   end

   initial begin
      #16_000_000;
      $display("hdlc_type3_frame_decoder_unit verification failed");
      $finish;
   end

endmodule
